/* hdl/msq_pkg.sv */
// ----------------------------------------------------------------------------
// msq_pkg
// Shared types and constants of the multi-server queue event step.
// ----------------------------------------------------------------------------
package msq_pkg;

	localparam int SERVER_COUNT_DEF = 5;
	localparam int QUEUE_DEPTH_DEF  = 128;

	localparam int TIME_W     = 32;
	localparam int ACC_W      = 48;
	localparam int SIDX_W     = 4;
	localparam int QLEN_W     = 8;
	localparam int GROUP_SIZE = 4;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [ACC_W-1:0]  acc_t;
	typedef logic [SIDX_W-1:0] sidx_t;

	localparam time_t NEVER = '1;

	typedef enum logic {
		EV_ARRIVAL   = 1'b0,
		EV_DEPARTURE = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_OVERFLOW = 2'd1,
		STATUS_HALTED   = 2'd2
	} status_t;

	// server table write: one entry per event
	typedef struct packed {
		logic  en;
		sidx_t idx;
		logic  busy;
		time_t due;
	} srv_upd_t;

	// earliest pending departure
	typedef struct packed {
		time_t due;
		sidx_t idx;
	} srv_sel_t;

	// lowest free server
	typedef struct packed {
		logic  found;
		sidx_t idx;
	} srv_free_t;

endpackage

/* hdl/msq_if.sv */
// ----------------------------------------------------------------------------
// msq_if
// Valid/ready channels for random samples in and event results out.
// ----------------------------------------------------------------------------
interface msq_sample_if;
	logic           valid;
	logic           ready;
	msq_pkg::time_t interarrival_gap;
	msq_pkg::time_t service_time;

	modport source (output valid, output interarrival_gap, output service_time, input ready);
	modport sink (input valid, input interarrival_gap, input service_time, output ready);
endinterface

interface msq_result_if;
	logic                        valid;
	logic                        ready;
	logic                        event_kind;
	logic [msq_pkg::SIDX_W-1:0]  server_index;
	msq_pkg::time_t              sim_time;
	msq_pkg::time_t              wait_time;
	logic [31:0]                 served_count;
	logic [msq_pkg::QLEN_W-1:0]  queue_length;
	msq_pkg::acc_t               total_wait;
	msq_pkg::acc_t               area_queue;
	msq_pkg::acc_t               area_all_busy;
	logic [1:0]                  status;

	modport source (output valid, output event_kind, output server_index, output sim_time,
		output wait_time, output served_count, output queue_length, output total_wait,
		output area_queue, output area_all_busy, output status, input ready);
	modport sink (input valid, input event_kind, input server_index, input sim_time,
		input wait_time, input served_count, input queue_length, input total_wait,
		input area_queue, input area_all_busy, input status, output ready);
endinterface

/* hdl/msq_ram.sv */
// ----------------------------------------------------------------------------
// msq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module msq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, hold between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/msq_server_table.sv */
// ----------------------------------------------------------------------------
// msq_server_table
// Busy flags and departure times per server, with a registered group-min
// stage feeding the earliest-departure select and a free-server encoder.
// ----------------------------------------------------------------------------
module msq_server_table #(
	parameter int SERVER_COUNT = msq_pkg::SERVER_COUNT_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  msq_pkg::srv_upd_t       upd,
	output logic [SERVER_COUNT-1:0] busy,
	output msq_pkg::srv_sel_t       sel,
	output msq_pkg::srv_free_t      free
);
	import msq_pkg::*;

	localparam int GROUPS = (SERVER_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;

	logic [SERVER_COUNT-1:0] busy_q;
	logic [SERVER_COUNT-1:0] busy_d;
	time_t                   dep_q [SERVER_COUNT];
	time_t                   dep_d [SERVER_COUNT];
	time_t                   grp_min_q [GROUPS];
	sidx_t                   grp_idx_q [GROUPS];
	time_t                   grp_min_d [GROUPS];
	sidx_t                   grp_idx_d [GROUPS];

	// apply the one entry write of this cycle
	always_comb begin
		busy_d = busy_q;
		for (int i = 0; i < SERVER_COUNT; i++) begin
			dep_d[i] = dep_q[i];
			if (upd.en && upd.idx == SIDX_W'(i)) begin
				dep_d[i]  = upd.due;
				busy_d[i] = upd.busy;
			end
		end
	end

	// per-group earliest departure of the next state, lowest index on ties
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			grp_min_d[g] = NEVER;
			grp_idx_d[g] = '0;
		end
		for (int i = 0; i < SERVER_COUNT; i++) begin
			if (dep_d[i] < grp_min_d[i / GROUP_SIZE]) begin
				grp_min_d[i / GROUP_SIZE] = dep_d[i];
				grp_idx_d[i / GROUP_SIZE] = SIDX_W'(i);
			end
		end
	end

	// hold table and group minima
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			for (int i = 0; i < SERVER_COUNT; i++) begin
				dep_q[i] <= NEVER;
			end
			for (int g = 0; g < GROUPS; g++) begin
				grp_min_q[g] <= NEVER;
				grp_idx_q[g] <= '0;
			end
		end else begin
			busy_q <= busy_d;
			for (int i = 0; i < SERVER_COUNT; i++) begin
				dep_q[i] <= dep_d[i];
			end
			for (int g = 0; g < GROUPS; g++) begin
				grp_min_q[g] <= grp_min_d[g];
				grp_idx_q[g] <= grp_idx_d[g];
			end
		end
	end

	// final select across groups
	always_comb begin
		sel.due = NEVER;
		sel.idx = '0;
		for (int g = 0; g < GROUPS; g++) begin
			if (grp_min_q[g] < sel.due) begin
				sel.due = grp_min_q[g];
				sel.idx = grp_idx_q[g];
			end
		end
	end

	// lowest free server
	always_comb begin
		free.found = 1'b0;
		free.idx   = '0;
		for (int i = SERVER_COUNT - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free.found = 1'b1;
				free.idx   = SIDX_W'(i);
			end
		end
	end

	assign busy = busy_q;

`ifndef SYNTH
	for (genvar i = 0; i < SERVER_COUNT; i++) begin : g_chk
		a_idle_never: assert property (@(posedge clk) disable iff (!arst_n)
			!busy_q[i] |-> dep_q[i] == NEVER)
			else $error("idle server holds a departure time");
	end
	a_group_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		upd.en && upd.due < grp_min_d[0] && upd.idx < SIDX_W'(GROUP_SIZE)
		|=> grp_min_q[0] == $past(upd.due))
		else $error("group minimum missed an earlier departure");
`endif

endmodule

/* hdl/multi_server_queue_event_step.sv */
// Path: sample stage, select stage, then result register; any of them can stall.
// Flow: one event is selected, then written back to the event state before the
//   next is selected (read-modify-write of the event state).
// A new sample beat is taken while the previous result waits at the output.
// Reset (arst_n, asynchronous): clears control and statistics at once; the
//   waiting-arrivals memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// multi_server_queue_event_step
// One discrete event of a multi-server FIFO queue per accepted sample beat.
// ----------------------------------------------------------------------------
module multi_server_queue_event_step #(
	parameter int SERVER_COUNT = msq_pkg::SERVER_COUNT_DEF,
	parameter int QUEUE_DEPTH  = msq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	msq_sample_if.sink     sample,
	msq_result_if.source   result,
	input  logic           cfg_we,
	input  msq_pkg::time_t cfg_data
);
	import msq_pkg::*;

	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int PTR_W  = $clog2(QUEUE_DEPTH);
	localparam int PROD_W = CNT_W + TIME_W;
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	function automatic time_t add_sat32(time_t a, time_t b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? NEVER : s[TIME_W-1:0];
	endfunction

	function automatic acc_t add_sat48(acc_t a, acc_t b);
		logic [ACC_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ACC_W] ? '1 : s[ACC_W-1:0];
	endfunction

	// sample stage
	logic  vld_s1;
	time_t gap_s1, svc_s1;

	// select stage
	logic      vld_s2, dep_s2, all_busy_s2;
	time_t     t_s2, dt_s2, gap_s2, svc_s2;
	sidx_t     widx_s2;
	srv_free_t free_s2;

	// event state
	time_t            arrival_q, clock_q;
	logic [31:0]      served_q;
	acc_t             wsum_q, qarea_q, barea_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PTR_W-1:0] head_q, tail_q;
	logic             halted_q;

	// result register
	logic             out_vld_q;
	kind_t            o_kind_q;
	sidx_t            o_sidx_q;
	time_t            o_time_q, o_wait_q;
	logic [31:0]      o_served_q;
	logic [QLEN_W-1:0] o_qlen_q;
	acc_t             o_wsum_q, o_qarea_q, o_barea_q;
	status_t          o_status_q;

	logic                    eval_fire, apply_fire, dep_win;
	time_t                   t_raw, t_ev;
	logic [SERVER_COUNT-1:0] busy;
	srv_sel_t                sel;
	srv_free_t               free;
	srv_upd_t                upd, upd_g;
	time_t                   ram_rdata;
	logic                    ram_we, push, pop;

	time_t            new_due, next_arr, wait_v;
	logic [PROD_W-1:0] prod;
	kind_t            nx_kind;
	sidx_t            nx_sidx;
	time_t            nx_wait, nx_clock, nx_arr;
	status_t          nx_status;
	logic [31:0]      nx_served;
	acc_t             nx_wsum, nx_qarea, nx_barea;
	logic [CNT_W-1:0] nx_cnt;
	logic             nx_halt;

	msq_server_table #(
		.SERVER_COUNT(SERVER_COUNT)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.upd   (upd_g),
		.busy  (busy),
		.sel   (sel),
		.free  (free)
	);

	msq_ram #(
		.WIDTH(TIME_W),
		.DEPTH(QUEUE_DEPTH),
		.AW   (PTR_W)
	) u_fifo_ram (
		.clk  (clk),
		.we   (ram_we && apply_fire),
		.waddr(tail_q),
		.wdata(t_s2),
		.re   (eval_fire),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	// handshake: select waits until the previous event is written back
	assign eval_fire    = vld_s1 && !vld_s2;
	assign apply_fire   = vld_s2 && (!out_vld_q || result.ready);
	assign sample.ready = !vld_s1 || eval_fire;

	// pick the earliest event, clamp to the clock
	always_comb begin
		dep_win = sel.due < arrival_q;
		t_raw   = dep_win ? sel.due : arrival_q;
		t_ev    = (t_raw < clock_q) ? clock_q : t_raw;
	end

	// capture sample beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (sample.valid && sample.ready) begin
			vld_s1 <= 1'b1;
		end else if (eval_fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			gap_s1 <= sample.interarrival_gap;
			svc_s1 <= sample.service_time;
		end
	end

	// register the selected event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (eval_fire) begin
			vld_s2 <= 1'b1;
		end else if (apply_fire) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_fire) begin
			t_s2        <= t_ev;
			dt_s2       <= t_ev - clock_q;
			gap_s2      <= gap_s1;
			svc_s2      <= svc_s1;
			dep_s2      <= dep_win;
			widx_s2     <= sel.idx;
			free_s2     <= free;
			all_busy_s2 <= &busy;
		end
	end

	// work out the event's effect
	always_comb begin
		new_due  = add_sat32(t_s2, svc_s2);
		next_arr = add_sat32(t_s2, gap_s2);
		prod     = PROD_W'(cnt_q) * PROD_W'(dt_s2);
		wait_v   = (t_s2 >= ram_rdata) ? t_s2 - ram_rdata : '0;

		upd       = '0;
		ram_we    = 1'b0;
		push      = 1'b0;
		pop       = 1'b0;
		nx_kind   = EV_ARRIVAL;
		nx_sidx   = '0;
		nx_wait   = '0;
		nx_status = STATUS_OK;
		nx_clock  = clock_q;
		nx_arr    = arrival_q;
		nx_served = served_q;
		nx_wsum   = wsum_q;
		nx_qarea  = qarea_q;
		nx_barea  = barea_q;
		nx_cnt    = cnt_q;
		nx_halt   = halted_q;

		if (halted_q) begin
			nx_status = STATUS_HALTED;
		end else begin
			nx_clock = t_s2;
			nx_qarea = add_sat48(qarea_q, ACC_W'(prod));
			if (all_busy_s2) begin
				nx_barea = add_sat48(barea_q, ACC_W'(dt_s2));
			end
			if (!dep_s2) begin
				nx_arr = next_arr;
				if (free_s2.found) begin
					upd.en    = 1'b1;
					upd.idx   = free_s2.idx;
					upd.busy  = 1'b1;
					upd.due   = new_due;
					nx_served = served_q + 32'd1;
					nx_sidx   = free_s2.idx;
				end else if (cnt_q == CNT_FULL) begin
					nx_halt   = 1'b1;
					nx_status = STATUS_OVERFLOW;
				end else begin
					ram_we = 1'b1;
					push   = 1'b1;
					nx_cnt = cnt_q + CNT_W'(1);
				end
			end else begin
				nx_kind = EV_DEPARTURE;
				nx_sidx = widx_s2;
				upd.en  = 1'b1;
				upd.idx = widx_s2;
				if (cnt_q == '0) begin
					upd.busy = 1'b0;
					upd.due  = NEVER;
				end else begin
					// start the head of the line on this server
					pop       = 1'b1;
					upd.busy  = 1'b1;
					upd.due   = new_due;
					nx_cnt    = cnt_q - CNT_W'(1);
					nx_wait   = wait_v;
					nx_wsum   = add_sat48(wsum_q, ACC_W'(wait_v));
					nx_served = served_q + 32'd1;
				end
			end
		end
	end

	always_comb begin
		upd_g    = upd;
		upd_g.en = upd.en && apply_fire;
	end

	// write back event state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arrival_q <= '0;
			clock_q   <= '0;
			served_q  <= '0;
			wsum_q    <= '0;
			qarea_q   <= '0;
			barea_q   <= '0;
			cnt_q     <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			halted_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				arrival_q <= cfg_data;
			end else if (apply_fire) begin
				arrival_q <= nx_arr;
			end
			if (apply_fire) begin
				clock_q  <= nx_clock;
				served_q <= nx_served;
				wsum_q   <= nx_wsum;
				qarea_q  <= nx_qarea;
				barea_q  <= nx_barea;
				cnt_q    <= nx_cnt;
				halted_q <= nx_halt;
				if (push) begin
					tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
				end
				if (pop) begin
					head_q <= (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
				end
			end
		end
	end

	// result register: hold until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (apply_fire) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply_fire) begin
			o_kind_q   <= nx_kind;
			o_sidx_q   <= nx_sidx;
			o_time_q   <= nx_clock;
			o_wait_q   <= nx_wait;
			o_served_q <= nx_served;
			o_qlen_q   <= QLEN_W'(nx_cnt);
			o_wsum_q   <= nx_wsum;
			o_qarea_q  <= nx_qarea;
			o_barea_q  <= nx_barea;
			o_status_q <= nx_status;
		end
	end

	assign result.valid         = out_vld_q;
	assign result.event_kind    = o_kind_q;
	assign result.server_index  = o_sidx_q;
	assign result.sim_time      = o_time_q;
	assign result.wait_time     = o_wait_q;
	assign result.served_count  = o_served_q;
	assign result.queue_length  = o_qlen_q;
	assign result.total_wait    = o_wsum_q;
	assign result.area_queue    = o_qarea_q;
	assign result.area_all_busy = o_barea_q;
	assign result.status        = o_status_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("waiting count beyond queue depth");
	a_wait_all_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> &busy)
		else $error("customers wait while a server is free");
	a_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> !eval_fire)
		else $error("event selected before previous write-back");
	a_overflow_halts: assert property (@(posedge clk) disable iff (!arst_n)
		apply_fire && nx_status == STATUS_OVERFLOW |=> halted_q)
		else $error("overflow did not halt");
	a_halt_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q && apply_fire |=> clock_q == $past(clock_q) && cnt_q == $past(cnt_q))
		else $error("state changed while halted");
`endif

endmodule
